/* sv/rdp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rdp_pkg: shared constants and types for the radar dot plotter
// Widths of the serial datapath, register indexes and the quantizer.
// ----------------------------------------------------------------------------
package rdp_pkg;

  localparam int SLOTS_DEF = 64;

  // digit width of all serial units
  localparam int DIGIT      = 4;

  localparam int W_WORLD    = 32;
  localparam int W_DELTA    = W_WORLD + 1;
  localparam int W_TRIG     = 16;
  localparam int W_ROT      = 50;
  localparam int W_INV      = 32;
  localparam int NORM_SHIFT = 30;
  localparam int W_MAG      = 18;
  localparam int W_NACC     = NORM_SHIFT + W_MAG;
  localparam int W_NORM     = W_MAG + 1;
  localparam int W_R2       = 2 * W_MAG;
  localparam int W_COLOR    = 32;
  localparam int W_SLOT     = 6;
  localparam int W_DOT      = 8;

  localparam int ROT_STEPS  = W_TRIG / DIGIT;
  localparam int NORM_STEPS = W_INV / DIGIT;
  localparam int RAD_STEPS  = (W_MAG + DIGIT - 1) / DIGIT;
  localparam int W_RSR      = RAD_STEPS * DIGIT;

  localparam logic [W_MAG-1:0] NORM_SAT  = W_MAG'(131072);
  localparam int               NORM_ONE  = 65536;
  localparam logic [W_R2-1:0]  R2_LIMIT  = W_R2'(64'h1_0000_0000);
  localparam int               Q_SHIFT   = 17;
  localparam int               W_QM      = W_NORM + 1;
  localparam int               W_QP      = W_QM + W_DOT;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int REG_IW = CFG_AW - 2;
  localparam logic [REG_IW-1:0] REG_CENTER_X      = REG_IW'(0);
  localparam logic [REG_IW-1:0] REG_CENTER_Y      = REG_IW'(1);
  localparam logic [REG_IW-1:0] REG_COS_HEADING   = REG_IW'(2);
  localparam logic [REG_IW-1:0] REG_SIN_HEADING   = REG_IW'(3);
  localparam logic [REG_IW-1:0] REG_INV_RADIUS    = REG_IW'(4);
  localparam logic [REG_IW-1:0] REG_DEFAULT_COLOR = REG_IW'(5);

  localparam logic signed [W_TRIG-1:0] COS_RESET = W_TRIG'(16384);
  localparam logic [W_INV-1:0]         INV_RESET = W_INV'(65536);

  typedef struct packed {
    logic load;
    logic step;
  } rdp_ctl_t;

  // ((n + 1.0) * 255) >> 17, clamped to 0..255
  function automatic logic [W_DOT-1:0] quantize(input logic signed [W_NORM-1:0] n);
    logic signed [W_QM-1:0] m;
    logic [W_QP-1:0]        mu;
    logic [W_QP-1:0]        t;
    logic [W_QP-Q_SHIFT-1:0] q;
    m  = W_QM'(n) + W_QM'(NORM_ONE);
    mu = W_QP'(unsigned'(m));
    t  = (mu << W_DOT) - mu;
    q  = t[W_QP-1:Q_SHIFT];
    if (m[W_QM-1]) begin
      return '0;
    end else if (q > (W_QP-Q_SHIFT)'(255)) begin
      return '1;
    end else begin
      return q[W_DOT-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* sv/rdp_rotator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rdp_rotator: digit-serial rotation of the center-relative position
// Forms rx = dx*cos - dy*sin and ry = dx*sin + dy*cos, one 4-bit digit of
// cos and sin per step cycle, most significant digit first.
// ----------------------------------------------------------------------------
module rdp_rotator (
  input  logic                                  clk,
  input  rdp_pkg::rdp_ctl_t                     ctl,
  input  logic signed [rdp_pkg::W_WORLD-1:0]    world_x,
  input  logic signed [rdp_pkg::W_WORLD-1:0]    world_y,
  input  logic signed [rdp_pkg::W_WORLD-1:0]    center_x,
  input  logic signed [rdp_pkg::W_WORLD-1:0]    center_y,
  input  logic signed [rdp_pkg::W_TRIG-1:0]     cos_h,
  input  logic signed [rdp_pkg::W_TRIG-1:0]     sin_h,
  output logic signed [rdp_pkg::W_ROT-1:0]      rot_x,
  output logic signed [rdp_pkg::W_ROT-1:0]      rot_y
);
  import rdp_pkg::*;

  localparam int W_PP = W_DELTA + DIGIT + 1;

  logic signed [W_DELTA-1:0] dx_r, dy_r;
  logic [W_TRIG-1:0]         cos_sr_r, sin_sr_r;
  logic                      first_r;
  logic signed [W_ROT-1:0]   acc_x_r, acc_y_r, acc_x_nxt, acc_y_nxt;
  logic [DIGIT-1:0]          cos_nib, sin_nib;
  logic signed [DIGIT:0]     dc, ds;
  logic signed [W_PP-1:0]    p_xc, p_xs, p_yc, p_ys;

  assign cos_nib = cos_sr_r[W_TRIG-1 -: DIGIT];
  assign sin_nib = sin_sr_r[W_TRIG-1 -: DIGIT];

  // top digit carries the sign, the rest are plain
  assign dc = first_r ? signed'({cos_nib[DIGIT-1], cos_nib}) : signed'({1'b0, cos_nib});
  assign ds = first_r ? signed'({sin_nib[DIGIT-1], sin_nib}) : signed'({1'b0, sin_nib});

  assign p_xc = dx_r * dc;
  assign p_xs = dx_r * ds;
  assign p_yc = dy_r * dc;
  assign p_ys = dy_r * ds;

  assign acc_x_nxt = (acc_x_r <<< DIGIT) + W_ROT'(p_xc) - W_ROT'(p_ys);
  assign acc_y_nxt = (acc_y_r <<< DIGIT) + W_ROT'(p_xs) + W_ROT'(p_yc);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dx_r     <= W_DELTA'(world_x) - W_DELTA'(center_x);
      dy_r     <= W_DELTA'(world_y) - W_DELTA'(center_y);
      cos_sr_r <= cos_h;
      sin_sr_r <= sin_h;
      first_r  <= 1'b1;
      acc_x_r  <= '0;
      acc_y_r  <= '0;
    end else if (ctl.step) begin
      cos_sr_r <= cos_sr_r << DIGIT;
      sin_sr_r <= sin_sr_r << DIGIT;
      first_r  <= 1'b0;
      acc_x_r  <= acc_x_nxt;
      acc_y_r  <= acc_y_nxt;
    end
  end

  assign rot_x = acc_x_r;
  assign rot_y = acc_y_r;

endmodule
`default_nettype wire

/* sv/rdp_normalizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rdp_normalizer: digit-serial scaling by the reciprocal radius
// |v| * inv_radius >> 30, saturated to 2.0 (Q16), one digit of inv_radius per
// step cycle. The sum only grows, so a sticky flag catches saturation early.
// ----------------------------------------------------------------------------
module rdp_normalizer (
  input  logic                               clk,
  input  rdp_pkg::rdp_ctl_t                  ctl,
  input  logic signed [rdp_pkg::W_ROT-1:0]   value,
  input  logic                               negate,
  input  logic [rdp_pkg::W_INV-1:0]          inv_radius,
  output logic signed [rdp_pkg::W_NORM-1:0]  norm
);
  import rdp_pkg::*;

  localparam int W_PROD = W_ROT + DIGIT;
  localparam int W_SUM  = W_PROD + 1;

  logic [W_ROT-1:0]         mag_r;
  logic                     neg_r;
  logic [W_INV-1:0]         inv_sr_r;
  logic [W_NACC-1:0]        acc_r;
  logic                     sat_r;
  logic [W_PROD-1:0]        prod;
  logic [W_SUM-1:0]         sum;
  logic                     over;
  logic [W_MAG-1:0]         q;
  logic [W_MAG-1:0]         res;
  logic signed [W_NORM-1:0] res_s;

  assign prod = W_PROD'(mag_r) * W_PROD'(inv_sr_r[W_INV-1 -: DIGIT]);
  assign sum  = W_SUM'({acc_r, {DIGIT{1'b0}}}) + W_SUM'(prod);
  assign over = |sum[W_SUM-1:W_NACC];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag_r    <= value[W_ROT-1] ? W_ROT'(-value) : W_ROT'(value);
      neg_r    <= value[W_ROT-1] ^ negate;
      inv_sr_r <= inv_radius;
      acc_r    <= '0;
      sat_r    <= 1'b0;
    end else if (ctl.step) begin
      inv_sr_r <= inv_sr_r << DIGIT;
      acc_r    <= sum[W_NACC-1:0];
      sat_r    <= sat_r | over;
    end
  end

  assign q     = acc_r[W_NACC-1:NORM_SHIFT];
  assign res   = (sat_r || (q > NORM_SAT)) ? NORM_SAT : q;
  assign res_s = signed'({1'b0, res});
  assign norm  = neg_r ? -res_s : res_s;

endmodule
`default_nettype wire

/* sv/rdp_radius.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rdp_radius: digit-serial unit circle test
// Accumulates nx*nx + ny*ny one digit per step and flags a sum above 2^32.
// ----------------------------------------------------------------------------
module rdp_radius (
  input  logic                               clk,
  input  rdp_pkg::rdp_ctl_t                  ctl,
  input  logic signed [rdp_pkg::W_NORM-1:0]  norm_x,
  input  logic signed [rdp_pkg::W_NORM-1:0]  norm_y,
  output logic                               outside
);
  import rdp_pkg::*;

  localparam int W_PROD = W_MAG + DIGIT;

  logic [W_MAG-1:0]  mag_x, mag_y;
  logic [W_MAG-1:0]  bx_r, by_r;
  logic [W_RSR-1:0]  ax_sr_r, ay_sr_r;
  logic [W_R2-1:0]   acc_r, acc_nxt;
  logic [W_PROD-1:0] px, py;

  assign mag_x = norm_x[W_NORM-1] ? W_MAG'(-norm_x) : W_MAG'(norm_x);
  assign mag_y = norm_y[W_NORM-1] ? W_MAG'(-norm_y) : W_MAG'(norm_y);

  assign px = W_PROD'(bx_r) * W_PROD'(ax_sr_r[W_RSR-1 -: DIGIT]);
  assign py = W_PROD'(by_r) * W_PROD'(ay_sr_r[W_RSR-1 -: DIGIT]);
  assign acc_nxt = (acc_r << DIGIT) + W_R2'(px) + W_R2'(py);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bx_r    <= mag_x;
      by_r    <= mag_y;
      ax_sr_r <= W_RSR'(mag_x);
      ay_sr_r <= W_RSR'(mag_y);
      acc_r   <= '0;
    end else if (ctl.step) begin
      ax_sr_r <= ax_sr_r << DIGIT;
      ay_sr_r <= ay_sr_r << DIGIT;
      acc_r   <= acc_nxt;
    end
  end

  assign outside = acc_r > R2_LIMIT;

endmodule
`default_nettype wire

/* sv/radar_dot_plotter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// radar_dot_plotter: places world objects as dots on a circular radar map
// Input stream: in_tuser[0] = 0 opens a frame, 1 presents an object at
// world (x, y). A frame word yields one result with out_tuser = 1 (clear
// all slots, data zero) and restarts the slot count. An object is rotated,
// scaled by inv_radius, dropped outside the unit circle, otherwise
// quantized to 0..255 and given the next of SLOTS slots; once all slots
// are used, objects are dropped until the next frame word.
// One word is worked on at a time. From accept to the next accept an object
// passes through 4 rotation digits, a load plus 8 digits of inv_radius, a
// load plus 5 digits of the radius sum, the emit state and the idle state;
// a kept object's result is registered as it leaves the emit state. A frame
// word goes through the emit state only, a dropped object on a full map nowhere.
// A finished result waits in the output register; the next word is taken
// while it waits, and a stalled receiver only holds the emit cycle.
// Reset (synchronous, rst_n low) restores the registers to their defaults,
// clears the slot count and empties the output register.
// Registers on the APB port at 4*i: center_x, center_y, cos_heading,
// sin_heading, inv_radius, default_color.
// ----------------------------------------------------------------------------
module radar_dot_plotter #(
  parameter int SLOTS = rdp_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: world_x[31:0], world_y[63:32], own_color[95:64]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [95:0]                 in_tdata,
  // in_tuser: action[0], has_color[1]
  input  logic [1:0]                  in_tuser,
  // out_tdata: slot[5:0], dot_x[13:6], dot_y[21:14], dot_color[53:22], zero pad
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [55:0]                 out_tdata,
  // out_tuser: frame_clear[0]
  output logic [0:0]                  out_tuser,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rdp_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import rdp_pkg::*;

  localparam int SLOT_CW = $clog2(SLOTS + 1);
  localparam int CNT_W   = $clog2(NORM_STEPS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROT  = 5'b00010,
    S_NORM = 5'b00100,
    S_RAD  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SLOT_CW-1:0] slot_cnt_r;
  logic               frame_r;
  logic [W_COLOR-1:0] color_r;

  logic signed [W_WORLD-1:0] center_x_r, center_y_r;
  logic signed [W_TRIG-1:0]  cos_r, sin_r;
  logic [W_INV-1:0]          inv_r;
  logic [W_COLOR-1:0]        dcolor_r;

  logic                 out_tvalid_r;
  logic [55:0]          out_tdata_r;
  logic [0:0]           out_tuser_r;

  logic                 cfg_wr;
  logic [REG_IW-1:0]    cfg_idx;
  logic                 in_accept, is_obj, full;
  logic                 out_free, drop, emit_fire;
  rdp_ctl_t             rot_ctl, norm_ctl, rad_ctl;
  logic signed [W_ROT-1:0]  rot_x, rot_y;
  logic signed [W_NORM-1:0] norm_x, norm_y;
  logic                 outside;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      cos_r      <= COS_RESET;
      sin_r      <= '0;
      inv_r      <= INV_RESET;
      dcolor_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CENTER_X:      center_x_r <= cfg_pwdata;
        REG_CENTER_Y:      center_y_r <= cfg_pwdata;
        REG_COS_HEADING:   cos_r      <= cfg_pwdata[W_TRIG-1:0];
        REG_SIN_HEADING:   sin_r      <= cfg_pwdata[W_TRIG-1:0];
        REG_INV_RADIUS:    inv_r      <= cfg_pwdata;
        REG_DEFAULT_COLOR: dcolor_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER_X:      cfg_prdata = center_x_r;
      REG_CENTER_Y:      cfg_prdata = center_y_r;
      REG_COS_HEADING:   cfg_prdata = {16'b0, cos_r};
      REG_SIN_HEADING:   cfg_prdata = {16'b0, sin_r};
      REG_INV_RADIUS:    cfg_prdata = inv_r;
      REG_DEFAULT_COLOR: cfg_prdata = dcolor_r;
      default:           cfg_prdata = '0;
    endcase
  end

  // sequencing
  assign in_tready = (st_r == S_IDLE);
  assign in_accept = in_tvalid & in_tready;
  assign is_obj    = in_tuser[0];
  assign full      = slot_cnt_r >= SLOT_CW'(SLOTS);
  assign out_free  = !out_tvalid_r || out_tready;
  assign drop      = !frame_r && outside;
  assign emit_fire = (st_r == S_EMIT) && !drop && out_free;

  assign rot_ctl.load  = in_accept & is_obj & !full;
  assign rot_ctl.step  = (st_r == S_ROT);
  assign norm_ctl.load = (st_r == S_NORM) && (cnt_r == '0);
  assign norm_ctl.step = (st_r == S_NORM) && (cnt_r != '0);
  assign rad_ctl.load  = (st_r == S_RAD) && (cnt_r == '0);
  assign rad_ctl.step  = (st_r == S_RAD) && (cnt_r != '0);

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_accept && !is_obj) begin
          st_nxt = S_EMIT;
        end else if (rot_ctl.load) begin
          st_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (cnt_r == CNT_W'(ROT_STEPS - 1)) begin
          st_nxt  = S_NORM;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_NORM: begin
        if (cnt_r == CNT_W'(NORM_STEPS)) begin
          st_nxt  = S_RAD;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RAD: begin
        if (cnt_r == CNT_W'(RAD_STEPS)) begin
          st_nxt  = S_EMIT;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (drop || out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      cnt_r      <= '0;
      slot_cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (emit_fire) begin
        slot_cnt_r <= frame_r ? '0 : slot_cnt_r + 1'b1;
      end
    end
  end

  // hold the word's kind and color while it is in flight
  always_ff @(posedge clk) begin
    if (in_accept) begin
      frame_r <= !is_obj;
      color_r <= in_tuser[1] ? in_tdata[95:64] : dcolor_r;
    end
  end

  rdp_rotator u_rot (
    .clk      (clk),
    .ctl      (rot_ctl),
    .world_x  (in_tdata[31:0]),
    .world_y  (in_tdata[63:32]),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .cos_h    (cos_r),
    .sin_h    (sin_r),
    .rot_x    (rot_x),
    .rot_y    (rot_y)
  );

  // map X from the rotated Y axis, map Y from the negated rotated X
  rdp_normalizer u_norm_x (
    .clk        (clk),
    .ctl        (norm_ctl),
    .value      (rot_y),
    .negate     (1'b0),
    .inv_radius (inv_r),
    .norm       (norm_x)
  );

  rdp_normalizer u_norm_y (
    .clk        (clk),
    .ctl        (norm_ctl),
    .value      (rot_x),
    .negate     (1'b1),
    .inv_radius (inv_r),
    .norm       (norm_y)
  );

  rdp_radius u_rad (
    .clk     (clk),
    .ctl     (rad_ctl),
    .norm_x  (norm_x),
    .norm_y  (norm_y),
    .outside (outside)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (frame_r) begin
        out_tdata_r <= '0;
        out_tuser_r <= 1'b1;
      end else begin
        out_tdata_r <= {2'b0, color_r, quantize(norm_y), quantize(norm_x),
                        W_SLOT'(slot_cnt_r)};
        out_tuser_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_cnt_r <= SLOT_CW'(SLOTS))
    else $error("slot count beyond map size");

  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT && !frame_r) |-> !full)
    else $error("object in flight on a full map");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r[0]) |-> (out_tdata_r == '0))
    else $error("clear marker carries data");

  a_clear_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && frame_r) |=> (slot_cnt_r == '0))
    else $error("frame word did not restart slot count");

  a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && !frame_r) |=> (slot_cnt_r == SLOT_CW'($past(slot_cnt_r) + 1'b1)))
    else $error("dot did not advance slot count");

endmodule
`default_nettype wire

/* tb/sv/rdp_tb_pkg.sv */
// ----------------------------------------------------------------------------
// rdp_tb_pkg: codes shared by the radar dot plotter testbench files
// Word kinds on the input stream, as carried in in_tuser[0].
// ----------------------------------------------------------------------------
package rdp_tb_pkg;

  typedef enum logic {
    ACT_FRAME  = 1'b0,
    ACT_OBJECT = 1'b1
  } action_e;

endpackage

/* tb/sv/rdp_dot_checker.sv */
// ----------------------------------------------------------------------------
// rdp_dot_checker: scoreboard for the radar dot plotter
// Watches the register port, the object stream and the dot stream. Keeps its
// own copy of the registers and the slot count, computes the dot expected
// from each word that yields one and checks dots field by field in order.
// ----------------------------------------------------------------------------
module rdp_dot_checker
  import rdp_pkg::*;
  import rdp_tb_pkg::*;
#(
  parameter int NUM_SLOTS = SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [95:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [55:0]         out_tdata,
  input  logic [0:0]          out_tuser,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  input  logic                cfg_pready,
  output int unsigned         mismatches,
  output int unsigned         dots_pending
);

  localparam longint UNIT     = 65536;
  localparam longint CAP      = 131072;
  localparam longint RIM      = 64'h1_0000_0000;
  localparam int     MAX_LOGS = 40;

  typedef struct packed {
    logic        clear;
    logic [5:0]  slot;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [31:0] color;
  } dot_t;

  logic signed [31:0] ctr_x;
  logic signed [31:0] ctr_y;
  logic signed [15:0] cos_h;
  logic signed [15:0] sin_h;
  logic [31:0]        inv_radius;
  logic [31:0]        dflt_color;
  int unsigned        slots_used;
  dot_t               plotted[$];

  initial begin
    mismatches   = 0;
    dots_pending = 0;
  end

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_LOGS) begin
      $display("dot check: %s got %0h want %0h at %0t", field, got, want, $realtime);
    end
  endtask

  // Q14 world value scaled by inv_radius to Q16, saturated, sign restored
  function automatic longint to_unit(input longint v);
    logic [63:0] mag;
    logic [95:0] prod;
    logic [63:0] res;
    mag  = (v < 0) ? 64'(-v) : 64'(v);
    prod = 96'(mag) * 96'(inv_radius);
    res  = 64'(prod >> 30);
    if (res > 64'(CAP)) begin
      res = 64'(CAP);
    end
    return (v < 0) ? -longint'(res) : longint'(res);
  endfunction

  function automatic logic [7:0] to_pixel(input longint n);
    longint m;
    longint q;
    m = n + UNIT;
    if (m < 0) begin
      return 8'd0;
    end
    q = (m * 255) >>> 17;
    if (q > 255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

  task automatic take_word(input logic [95:0] data, input logic [1:0] user);
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    longint             dx;
    longint             dy;
    longint             rx;
    longint             ry;
    longint             nx;
    longint             ny;
    dot_t               d;
    wx = data[31:0];
    wy = data[63:32];
    d  = '0;
    if (action_e'(user[0]) == ACT_FRAME) begin
      slots_used = 0;
      d.clear    = 1'b1;
      plotted.push_back(d);
    end else if (slots_used < NUM_SLOTS) begin
      dx = longint'(wx) - longint'(ctr_x);
      dy = longint'(wy) - longint'(ctr_y);
      rx = dx * longint'(cos_h) - dy * longint'(sin_h);
      ry = dx * longint'(sin_h) + dy * longint'(cos_h);
      // map X follows rotated Y, map Y follows negated rotated X
      nx = to_unit(ry);
      ny = -to_unit(rx);
      if (nx * nx + ny * ny <= RIM) begin
        d.slot  = slots_used[5:0];
        d.px    = to_pixel(nx);
        d.py    = to_pixel(ny);
        d.color = user[1] ? data[95:64] : dflt_color;
        plotted.push_back(d);
        slots_used++;
      end
    end
  endtask

  task automatic check_dot();
    dot_t want;
    if (plotted.size() == 0) begin
      report("dot with nothing pending", 32'(out_tdata), 32'h0);
    end else begin
      want = plotted.pop_front();
      if (out_tuser[0] !== want.clear) report("frame_clear", 32'(out_tuser[0]), 32'(want.clear));
      if (out_tdata[5:0] !== want.slot) report("slot", 32'(out_tdata[5:0]), 32'(want.slot));
      if (out_tdata[13:6] !== want.px) report("dot_x", 32'(out_tdata[13:6]), 32'(want.px));
      if (out_tdata[21:14] !== want.py) report("dot_y", 32'(out_tdata[21:14]), 32'(want.py));
      if (out_tdata[53:22] !== want.color) report("dot_color", out_tdata[53:22], want.color);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ctr_x      = '0;
      ctr_y      = '0;
      cos_h      = 16'sd16384;
      sin_h      = '0;
      inv_radius = 32'd65536;
      dflt_color = '0;
      slots_used = 0;
      plotted.delete();
    end else begin
      // retire older dots before queueing the word taken at this edge
      if (out_tvalid && out_tready) begin
        check_dot();
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_CENTER_X:      ctr_x      = cfg_pwdata;
          REG_CENTER_Y:      ctr_y      = cfg_pwdata;
          REG_COS_HEADING:   cos_h      = cfg_pwdata[15:0];
          REG_SIN_HEADING:   sin_h      = cfg_pwdata[15:0];
          REG_INV_RADIUS:    inv_radius = cfg_pwdata;
          REG_DEFAULT_COLOR: dflt_color = cfg_pwdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        take_word(in_tdata, in_tuser);
      end
    end
    dots_pending <= plotted.size();
  end

endmodule

/* tb/sv/radar_dot_plotter_tb.sv */
// ----------------------------------------------------------------------------
// radar_dot_plotter_tb: stimulus and verdict for the radar dot plotter
// Runs a directed set of map edge and frame cases on the reset registers,
// then several register settings (rotations, extreme centers and radii)
// each with random frames of objects, some long enough to fill all slots.
// Both streams idle at random; rdp_dot_checker predicts and compares.
// ----------------------------------------------------------------------------
module radar_dot_plotter_tb;
  import rdp_pkg::*;
  import rdp_tb_pkg::*;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [95:0]       in_tdata    = '0;
  logic [1:0]        in_tuser    = '0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [55:0]       out_tdata;
  logic [0:0]        out_tuser;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  logic              no_gaps     = 1'b0;
  int unsigned       mismatches;
  int unsigned       dots_pending;

  radar_dot_plotter dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  rdp_dot_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .mismatches, .dots_pending
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 9);
  end

  task automatic cfg_write(input logic [REG_IW-1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // hold the word until the block takes it; valid stays high on return
  task automatic send_word(input action_e act, input logic [31:0] wx, input logic [31:0] wy,
                           input logic hc, input logic [31:0] col);
    while (!no_gaps && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {col, wy, wx};
    in_tuser  <= {hc, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // drain: every expected dot delivered, then let a dropped object finish
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (dots_pending != 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] pc;
    logic signed [15:0] ps;
    logic [31:0]        pinv;
    logic [31:0]        pcol;
    int                 budget;
    int                 sent;
    int                 len;
    int                 roll;
    longint             reach;
    longint             ox;
    longint             oy;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: radius of 65536 world units around the origin
    send_word(ACT_FRAME, 32'h0, 32'h0, 1'b0, 32'h0);
    send_word(ACT_OBJECT, 32'h0, 32'h0, 1'b0, 32'h0);
    send_word(ACT_OBJECT, 32'h0, 32'h0, 1'b1, 32'hffff_ffff);
    send_word(ACT_OBJECT, 32'd65536, 32'h0, 1'b0, 32'h0);
    send_word(ACT_OBJECT, 32'd65537, 32'h0, 1'b1, 32'h1234_5678);
    send_word(ACT_OBJECT, 32'h0, 32'd65536, 1'b1, 32'h0);
    send_word(ACT_OBJECT, -32'sd65536, 32'h0, 1'b0, 32'h0);
    send_word(ACT_OBJECT, 32'h0, -32'sd65536, 1'b1, 32'hdead_beef);
    send_word(ACT_OBJECT, 32'd46340, 32'd46340, 1'b0, 32'h0);
    send_word(ACT_OBJECT, 32'd46341, 32'd46341, 1'b0, 32'h0);
    send_word(ACT_OBJECT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h8000_0001);
    send_word(ACT_OBJECT, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0);
    send_word(ACT_FRAME, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
    send_word(ACT_OBJECT, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h5a5a_5a5a);
    settle();

    for (int p = 1; p <= 8; p++) begin
      no_gaps = (p == 2);
      case (p)
        1: begin
          px = 0; py = 0; pc = 16'sd11585; ps = 16'sd11585;
          pinv = 32'd65536; pcol = 32'h1122_3344; budget = 300;
        end
        2: begin
          px = 32'sh8000_0000; py = 32'sh7fff_ffff; pc = -16'sd16384; ps = 16'sd16384;
          pinv = 32'd1; pcol = 32'hffff_ffff; budget = 200;
        end
        3: begin
          px = 32'sh7fff_ffff; py = 32'sh8000_0000; pc = 16'sh8000; ps = 16'sh7fff;
          pinv = 32'hffff_ffff; pcol = 32'h0; budget = 100;
        end
        4: begin
          px = 32'sh1234; py = -32'sh5678; pc = 16'sd0; ps = -16'sd16384;
          pinv = 32'h0; pcol = 32'ha5a5_a5a5; budget = 150;
        end
        default: begin
          px = $signed($urandom) >>> 2;
          py = $signed($urandom) >>> 2;
          case ($urandom_range(5))
            0: begin pc = 16'sd16384; ps = 16'sd0;     end
            1: begin pc = 16'sd0;     ps = 16'sd16384; end
            2: begin pc = -16'sd16384; ps = 16'sd0;    end
            3: begin pc = 16'sd11585; ps = -16'sd11585; end
            4: begin pc = 16'sd14189; ps = 16'sd8192;  end
            default: begin
              pc = 16'(int'($urandom_range(32768)) - 16384);
              ps = 16'(int'($urandom_range(32768)) - 16384);
            end
          endcase
          case ($urandom_range(4))
            0: pinv = 32'd65536;
            1: pinv = 32'd1 << 20;
            2: pinv = 32'd4096;
            3: pinv = 32'd256;
            default: pinv = $urandom;
          endcase
          pcol   = $urandom;
          budget = 300;
        end
      endcase
      cfg_write(REG_CENTER_X, px);
      cfg_write(REG_CENTER_Y, py);
      cfg_write(REG_COS_HEADING, 32'(pc));
      cfg_write(REG_SIN_HEADING, 32'(ps));
      cfg_write(REG_INV_RADIUS, pinv);
      cfg_write(REG_DEFAULT_COLOR, pcol);

      if (p == 2) begin
        send_word(ACT_OBJECT, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0);
        send_word(ACT_OBJECT, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h0f0f_0f0f);
      end

      // reach a bit past the map radius so some objects fall off the rim
      if (pinv == 0) begin
        reach = 64'h7fff_ffff;
      end else begin
        reach = (64'h1_0000_0000 / longint'(pinv)) * 5 / 4 + 1;
        if (reach > 64'h7fff_ffff) reach = 64'h7fff_ffff;
      end

      sent = 0;
      while (sent < budget) begin
        send_word(ACT_FRAME, $urandom, $urandom, 1'($urandom_range(1)), $urandom);
        sent++;
        len = ($urandom_range(99) < 25) ? $urandom_range(90, 64) : $urandom_range(40, 1);
        for (int k = 0; k < len && sent < budget; k++) begin
          roll = $urandom_range(99);
          if (roll < 85) begin
            ox = longint'($urandom_range(32'(2 * reach))) - reach;
            oy = longint'($urandom_range(32'(2 * reach))) - reach;
            send_word(ACT_OBJECT, 32'(longint'(px) + ox), 32'(longint'(py) + oy),
                      1'($urandom_range(1)), $urandom);
          end else if (roll < 95) begin
            send_word(ACT_OBJECT, $urandom, $urandom, 1'($urandom_range(1)), $urandom);
          end else begin
            // frame break in the middle of a run
            send_word(ACT_FRAME, $urandom, $urandom, 1'($urandom_range(1)), $urandom);
          end
          sent++;
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
